>>> rtl/ecpa_pkg.sv
// shared types and constants for the affine point adder
`default_nettype none

package ecpa_pkg;

    localparam int FIELD_BITS_DEF = 63;

    typedef struct packed {
        logic start;
    } mul_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_sts_t;

endpackage

`default_nettype wire

>>> rtl/ecpa_serial_mul.sv
// bit-serial modular multiplier, one multiplier bit per cycle, msb first
`default_nettype none

module ecpa_serial_mul #(
    parameter int W = ecpa_pkg::FIELD_BITS_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire ecpa_pkg::mul_req_t req,
    input  wire logic [W-1:0]     opa,
    input  wire logic [W-1:0]     opb,
    input  wire logic [W-1:0]     modulus,
    output ecpa_pkg::mul_sts_t    sts,
    output logic [W-1:0]          result
);
    import ecpa_pkg::*;

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  a_reg;
    logic [W-1:0]  b_reg;
    logic [W-1:0]  m_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [W:0] dbl;
    logic [W:0] dbl_red;
    logic [W:0] acc;

    always_comb begin
        dbl     = {r_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, m_reg}) ? dbl - {1'b0, m_reg} : dbl;
        acc     = dbl_red + (b_reg[W-1] ? {1'b0, a_reg} : '0);
        r_next  = (acc >= {1'b0, m_reg}) ? W'(acc - {1'b0, m_reg}) : W'(acc);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            r_reg <= '0;
            a_reg <= opa;
            b_reg <= opb;
            m_reg <= modulus;
        end else if (busy_reg) begin
            r_reg <= r_next;
            b_reg <= {b_reg[W-2:0], 1'b0};
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign result   = r_reg;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("multiplier done without a run");
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg)
        else $error("multiplier started while busy");
    a_result_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> r_reg < m_reg)
        else $error("multiplier result not reduced");
`endif

endmodule

`default_nettype wire

>>> rtl/ec_affine_point_add_core.sv
// affine point addition on a short weierstrass curve over a prime field
`default_nettype none

// Adds two affine points per transfer. Every field product runs through one
// bit-serial modular multiplier; the inverse of the slope denominator is
// d^(p-2) by square and multiply over FIELD_BITS exponent bits. A point
// addition needs at most 2*FIELD_BITS+11 products; a pass through case
// (either point at infinity, mirror points) still takes the six products
// that reduce the inputs. One item is worked at a time; a new item is
// taken while the previous result waits on the output register.
// Configuration writes must be issued only while the core is idle.

module ec_affine_point_add_core #(
    parameter int FIELD_BITS = ecpa_pkg::FIELD_BITS_DEF,
    localparam int IN_DATA_W  = ((4 * FIELD_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_W = ((2 * FIELD_BITS + 7) / 8) * 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [FIELD_BITS-1:0] cfg_data,
    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,  // first_x, first_y, second_x, second_y
    input  wire logic [1:0]            s_tuser,  // first_inf, second_inf
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,  // sum_x, sum_y
    output logic [0:0]                 m_tuser   // sum_inf
);
    import ecpa_pkg::*;

    localparam int W  = FIELD_BITS;
    localparam int CW = $clog2(W + 1);

    localparam logic [1:0] REG_MODULUS = 2'd0;
    localparam logic [1:0] REG_CURVE_A = 2'd1;

    localparam logic [2:0] RED_A     = 3'd0;
    localparam logic [2:0] RED_X1    = 3'd1;
    localparam logic [2:0] RED_Y1    = 3'd2;
    localparam logic [2:0] RED_X2    = 3'd3;
    localparam logic [2:0] RED_Y2    = 3'd4;
    localparam logic [2:0] RED_THREE = 3'd5;

    typedef enum logic [16:0] {
        ST_IDLE   = 17'h00001,
        ST_RED    = 17'h00002,
        ST_CASE   = 17'h00004,
        ST_DSQ    = 17'h00008,
        ST_DTRI   = 17'h00010,
        ST_DNUM   = 17'h00020,
        ST_CHD    = 17'h00040,
        ST_INVSQ  = 17'h00080,
        ST_INVMUL = 17'h00100,
        ST_SLOPE  = 17'h00200,
        ST_SSQ    = 17'h00400,
        ST_RX1    = 17'h00800,
        ST_RX2    = 17'h01000,
        ST_RYD    = 17'h02000,
        ST_RYM    = 17'h04000,
        ST_RYS    = 17'h08000,
        ST_DONE   = 17'h10000
    } state_t;

    function automatic logic [W-1:0] fadd(logic [W-1:0] x, logic [W-1:0] y,
                                          logic [W-1:0] m);
        logic [W:0] s;
        s = {1'b0, x} + {1'b0, y};
        return (s >= {1'b0, m}) ? W'(s - {1'b0, m}) : W'(s);
    endfunction

    function automatic logic [W-1:0] fsub(logic [W-1:0] x, logic [W-1:0] y,
                                          logic [W-1:0] m);
        return (x >= y) ? x - y : W'({1'b0, x} + {1'b0, m} - {1'b0, y});
    endfunction

    state_t state_reg;

    logic [W-1:0]  cfg_mod_reg;
    logic [W-1:0]  cfg_a_reg;

    logic [W-1:0]  m_reg;
    logic [W-1:0]  a_reg;
    logic [W-1:0]  three_reg;
    logic [W-1:0]  x1_reg, y1_reg, x2_reg, y2_reg;
    logic          inf1_reg, inf2_reg;
    logic [W-1:0]  t_reg, num_reg, den_reg, p_reg, s_reg;
    logic [W-1:0]  rx_reg, ry_reg;
    logic          rinf_reg;
    logic [W-1:0]  e_reg;
    logic [CW-1:0] ecnt_reg;
    logic [2:0]    red_idx_reg;
    logic          launched_reg;

    logic          out_valid_reg;
    logic          out_inf_reg;
    logic [W-1:0]  out_x_reg, out_y_reg;

    mul_req_t      mreq;
    mul_sts_t      msts;
    logic [W-1:0]  mul_a, mul_b, mul_res;
    logic          mul_state;
    logic          s_fire;
    logic          last_bit;
    logic          mirror;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign last_bit  = (ecnt_reg == CW'(1));
    assign mirror    = (x1_reg == x2_reg) && (y1_reg != y2_reg || y1_reg == '0);

    always_comb begin
        mul_state = 1'b0;
        mul_a     = x1_reg;
        mul_b     = x1_reg;
        case (state_reg)
            ST_RED: begin
                mul_state = 1'b1;
                mul_a     = W'(1);
                case (red_idx_reg)
                    RED_A:     mul_b = a_reg;
                    RED_X1:    mul_b = x1_reg;
                    RED_Y1:    mul_b = y1_reg;
                    RED_X2:    mul_b = x2_reg;
                    RED_Y2:    mul_b = y2_reg;
                    default:   mul_b = three_reg;
                endcase
            end
            ST_DSQ: begin
                mul_state = 1'b1;
            end
            ST_DTRI: begin
                mul_state = 1'b1;
                mul_a     = three_reg;
                mul_b     = t_reg;
            end
            ST_INVSQ: begin
                mul_state = 1'b1;
                mul_a     = p_reg;
                mul_b     = p_reg;
            end
            ST_INVMUL: begin
                mul_state = 1'b1;
                mul_a     = den_reg;
                mul_b     = p_reg;
            end
            ST_SLOPE: begin
                mul_state = 1'b1;
                mul_a     = num_reg;
                mul_b     = p_reg;
            end
            ST_SSQ: begin
                mul_state = 1'b1;
                mul_a     = s_reg;
                mul_b     = s_reg;
            end
            ST_RYM: begin
                mul_state = 1'b1;
                mul_a     = s_reg;
                mul_b     = t_reg;
            end
            default: begin
                mul_state = 1'b0;
            end
        endcase
    end

    assign mreq.start = mul_state && !launched_reg;

    ecpa_serial_mul #(
        .W (W)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .opa     (mul_a),
        .opb     (mul_b),
        .modulus (m_reg),
        .sts     (msts),
        .result  (mul_res)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_mod_reg <= W'(97);
            cfg_a_reg   <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_MODULUS: cfg_mod_reg <= cfg_data;
                REG_CURVE_A: cfg_a_reg   <= cfg_data;
                default:     ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            launched_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            red_idx_reg   <= '0;
            ecnt_reg      <= '0;
        end else begin
            if (state_reg == ST_DONE && (!out_valid_reg || m_tready)) begin
                out_valid_reg <= 1'b1;
            end else if (m_tvalid && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (mreq.start) begin
                launched_reg <= 1'b1;
            end else if (msts.done) begin
                launched_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        red_idx_reg <= RED_A;
                        state_reg   <= ST_RED;
                    end
                end
                ST_RED: begin
                    if (msts.done) begin
                        if (red_idx_reg == RED_THREE) begin
                            state_reg <= ST_CASE;
                        end else begin
                            red_idx_reg <= red_idx_reg + 1'b1;
                        end
                    end
                end
                ST_CASE: begin
                    if (inf1_reg || inf2_reg || mirror) begin
                        state_reg <= ST_DONE;
                    end else if (x1_reg == x2_reg) begin
                        state_reg <= ST_DSQ;
                    end else begin
                        state_reg <= ST_CHD;
                    end
                end
                ST_DSQ: begin
                    if (msts.done) begin
                        state_reg <= ST_DTRI;
                    end
                end
                ST_DTRI: begin
                    if (msts.done) begin
                        state_reg <= ST_DNUM;
                    end
                end
                ST_DNUM, ST_CHD: begin
                    ecnt_reg  <= CW'(W);
                    state_reg <= ST_INVSQ;
                end
                ST_INVSQ: begin
                    if (msts.done) begin
                        if (e_reg[W-1]) begin
                            state_reg <= ST_INVMUL;
                        end else begin
                            ecnt_reg  <= ecnt_reg - 1'b1;
                            state_reg <= last_bit ? ST_SLOPE : ST_INVSQ;
                        end
                    end
                end
                ST_INVMUL: begin
                    if (msts.done) begin
                        ecnt_reg  <= ecnt_reg - 1'b1;
                        state_reg <= last_bit ? ST_SLOPE : ST_INVSQ;
                    end
                end
                ST_SLOPE: begin
                    if (msts.done) begin
                        state_reg <= ST_SSQ;
                    end
                end
                ST_SSQ: begin
                    if (msts.done) begin
                        state_reg <= ST_RX1;
                    end
                end
                ST_RX1: state_reg <= ST_RX2;
                ST_RX2: state_reg <= ST_RYD;
                ST_RYD: state_reg <= ST_RYM;
                ST_RYM: begin
                    if (msts.done) begin
                        state_reg <= ST_RYS;
                    end
                end
                ST_RYS: state_reg <= ST_DONE;
                ST_DONE: begin
                    if (!out_valid_reg || m_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    m_reg     <= (cfg_mod_reg < W'(3)) ? W'(3) : cfg_mod_reg;
                    a_reg     <= cfg_a_reg;
                    three_reg <= W'(3);
                    x1_reg    <= s_tdata[W-1:0];
                    y1_reg    <= s_tdata[2*W-1:W];
                    x2_reg    <= s_tdata[3*W-1:2*W];
                    y2_reg    <= s_tdata[4*W-1:3*W];
                    inf1_reg  <= s_tuser[0];
                    inf2_reg  <= s_tuser[1];
                end
            end
            ST_RED: begin
                if (msts.done) begin
                    case (red_idx_reg)
                        RED_A:   a_reg     <= mul_res;
                        RED_X1:  x1_reg    <= mul_res;
                        RED_Y1:  y1_reg    <= mul_res;
                        RED_X2:  x2_reg    <= mul_res;
                        RED_Y2:  y2_reg    <= mul_res;
                        default: three_reg <= mul_res;
                    endcase
                end
            end
            ST_CASE: begin
                rinf_reg <= inf1_reg ? inf2_reg : (!inf2_reg && mirror);
                rx_reg   <= inf1_reg ? (inf2_reg ? '0 : x2_reg) : (inf2_reg ? x1_reg : '0);
                ry_reg   <= inf1_reg ? (inf2_reg ? '0 : y2_reg) : (inf2_reg ? y1_reg : '0);
            end
            ST_DSQ, ST_DTRI, ST_RYM: begin
                if (msts.done) begin
                    t_reg <= mul_res;
                end
            end
            ST_DNUM: begin
                num_reg <= fadd(t_reg, a_reg, m_reg);
                den_reg <= fadd(y1_reg, y1_reg, m_reg);
                x2_reg  <= x1_reg;
                p_reg   <= W'(1);
                e_reg   <= m_reg - W'(2);
            end
            ST_CHD: begin
                num_reg <= fsub(y2_reg, y1_reg, m_reg);
                den_reg <= fsub(x2_reg, x1_reg, m_reg);
                p_reg   <= W'(1);
                e_reg   <= m_reg - W'(2);
            end
            ST_INVSQ: begin
                if (msts.done) begin
                    p_reg <= mul_res;
                    if (!e_reg[W-1]) begin
                        e_reg <= {e_reg[W-2:0], 1'b0};
                    end
                end
            end
            ST_INVMUL: begin
                if (msts.done) begin
                    p_reg <= mul_res;
                    e_reg <= {e_reg[W-2:0], 1'b0};
                end
            end
            ST_SLOPE: begin
                if (msts.done) begin
                    s_reg <= mul_res;
                end
            end
            ST_SSQ: begin
                if (msts.done) begin
                    t_reg <= mul_res;
                end
            end
            ST_RX1: t_reg  <= fsub(t_reg, x1_reg, m_reg);
            ST_RX2: rx_reg <= fsub(t_reg, x2_reg, m_reg);
            ST_RYD: t_reg  <= fsub(x1_reg, rx_reg, m_reg);
            ST_RYS: ry_reg <= fsub(t_reg, y1_reg, m_reg);
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_inf_reg <= rinf_reg;
                    out_x_reg   <= rx_reg;
                    out_y_reg   <= ry_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_inf_reg;
    assign m_tdata  = OUT_DATA_W'({out_y_reg, out_x_reg});

`ifndef SYNTHESIS
    a_idle_mul_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !msts.busy)
        else $error("multiplier busy while idle");
    a_inf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("infinite sum with nonzero coordinates");
    a_mod_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (m_reg >= W'(3)))
        else $error("working modulus below three");
    a_done_in_mul_state: assert property (@(posedge aclk) disable iff (!aresetn)
        msts.done |-> (mul_state && launched_reg))
        else $error("product finished outside a multiply step");
`endif

endmodule

`default_nettype wire
